>>> rtl/glyph_cell_rasterizer_macros.svh
// assertion macros for the glyph cell rasterizer
// expects clk and arst_n in the scope of each use
`ifndef GLYPH_CELL_RASTERIZER_MACROS_SVH
`define GLYPH_CELL_RASTERIZER_MACROS_SVH

// same-cycle implication, checked while out of reset
`define GCR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked while out of reset
`define GCR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/gcr_pkg.sv
// shared types, constants, font rom and coordinate helpers
// used by every module of the glyph cell rasterizer
package gcr_pkg;

	localparam int COORD_BITS = 16;
	localparam int QDEPTH     = 2;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int QCNT_W     = $clog2(QDEPTH + 1);
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int CELL_CNT_W = 6;
	localparam int GLYPH_BITS = 64;
	localparam int GLYPH_NUM  = 96;

	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [6:0] CHAR_FIRST   = 7'h20;
	localparam logic [CELL_CNT_W-1:0] CELL_LAST = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_X  = 3'd0,
		REG_ORIGIN_Y  = 3'd1,
		REG_FORE      = 3'd2,
		REG_BACK      = 3'd3,
		REG_SCALE     = 3'd4,
		REG_TALL      = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [15:0] origin_x;
		logic [15:0] origin_y;
		logic [15:0] fore_color;
		logic [15:0] back_color;
		logic [3:0]  scale_factor;
		logic        tall_mode;
	} cfg_t;

	// one character waiting to be drawn
	typedef struct packed {
		logic [GLYPH_BITS-1:0] glyph;
		logic [COORD_BITS-1:0] cx;
		logic [COORD_BITS-1:0] cy;
	} job_t;

	typedef struct packed {
		logic [QCNT_W-1:0] count;
	} q_stat_t;

	typedef struct packed {
		logic                  busy;
		logic [CELL_CNT_W-1:0] cnt;
	} bk_stat_t;

	// row r of a glyph sits in bits 8r+7..8r, bit 0 of a row is the leftmost cell
	localparam logic [GLYPH_BITS-1:0] GLYPH_ROM [GLYPH_NUM] = '{
		64'h0000_0000_0000_0000, 64'h0018_0018_183C_3C18, 64'h0000_0000_0000_3636,
		64'h0036_367F_367F_3636, 64'h000C_1F30_1E03_3E0C, 64'h0063_660C_1833_6300,
		64'h006E_333B_6E1C_361C, 64'h0000_0000_0003_0606, 64'h0018_0C06_0606_0C18,
		64'h0006_0C18_1818_0C06, 64'h0000_663C_FF3C_6600, 64'h0000_0C0C_3F0C_0C00,
		64'h060C_0C00_0000_0000, 64'h0000_0000_3F00_0000, 64'h000C_0C00_0000_0000,
		64'h0001_0306_0C18_3060, 64'h003E_676F_7B73_633E, 64'h003F_0C0C_0C0C_0E0C,
		64'h003F_3306_1C30_331E, 64'h001E_3330_1C30_331E, 64'h0078_307F_3336_3C38,
		64'h001E_3330_301F_033F, 64'h001E_3333_1F03_061C, 64'h000C_0C0C_1830_333F,
		64'h001E_3333_1E33_331E, 64'h000E_1830_3E33_331E, 64'h000C_0C00_000C_0C00,
		64'h060C_0C00_000C_0C00, 64'h0018_0C06_0306_0C18, 64'h0000_3F00_003F_0000,
		64'h0006_0C18_3018_0C06, 64'h000C_000C_1830_331E, 64'h001E_037B_7B7B_633E,
		64'h0033_333F_3333_1E0C, 64'h003F_6666_3E66_663F, 64'h003C_6603_0303_663C,
		64'h001F_3666_6666_361F, 64'h007F_4616_1E16_467F, 64'h000F_0616_1E16_467F,
		64'h007C_6673_0303_663C, 64'h0033_3333_3F33_3333, 64'h001E_0C0C_0C0C_0C1E,
		64'h001E_3333_3030_3078, 64'h0067_6636_1E36_6667, 64'h007F_6646_0606_060F,
		64'h0063_636B_7F7F_7763, 64'h0063_6373_7B6F_6763, 64'h001C_3663_6363_361C,
		64'h000F_0606_3E66_663F, 64'h0038_1E3B_3333_331E, 64'h0067_6636_3E66_663F,
		64'h001E_3338_0E07_331E, 64'h001E_0C0C_0C0C_2D3F, 64'h003F_3333_3333_3333,
		64'h000C_1E33_3333_3333, 64'h0063_777F_6B63_6363, 64'h0063_361C_1C36_6363,
		64'h001E_0C0C_1E33_3333, 64'h007F_664C_1831_637F, 64'h001E_0606_0606_061E,
		64'h0040_6030_180C_0603, 64'h001E_1818_1818_181E, 64'h0000_0000_6336_1C08,
		64'hFF00_0000_0000_0000, 64'h0000_0000_0018_0C0C, 64'h006E_333E_301E_0000,
		64'h003B_6666_3E06_0607, 64'h001E_3303_331E_0000, 64'h006E_3333_3E30_3038,
		64'h001E_033F_331E_0000, 64'h000F_0606_0F06_361C, 64'h1F30_3E33_336E_0000,
		64'h0067_6666_6E36_0607, 64'h001E_0C0C_0C0E_000C, 64'h1E33_3330_3030_0030,
		64'h0067_361E_3666_0607, 64'h001E_0C0C_0C0C_0C0E, 64'h0063_6B7F_7F33_0000,
		64'h0033_3333_331F_0000, 64'h001E_3333_331E_0000, 64'h0F06_3E66_663B_0000,
		64'h7830_3E33_336E_0000, 64'h000F_0666_6E3B_0000, 64'h001F_301E_033E_0000,
		64'h0018_2C0C_0C3E_0C08, 64'h006E_3333_3333_0000, 64'h000C_1E33_3333_0000,
		64'h0036_7F7F_6B63_0000, 64'h0063_361C_3663_0000, 64'h1F30_3E33_3333_0000,
		64'h003F_260C_193F_0000, 64'h0038_0C0C_070C_0C38, 64'h0018_1818_0018_1818,
		64'h0007_0C0C_380C_0C07, 64'h0000_0000_0000_3B6E, 64'h0000_0000_0000_0000
	};

	// printable codes index the rom, everything else draws the blank glyph
	function automatic logic [GLYPH_BITS-1:0] glyph_bits(input logic [7:0] code);
		logic [6:0] idx;
		idx = 7'd0;
		if (!code[7] && (code[6:5] != 2'b00)) begin
			idx = code[6:0] - CHAR_FIRST;
		end
		return GLYPH_ROM[idx];
	endfunction

	// sign-extend a 16-bit register into the coordinate width
	function automatic logic [COORD_BITS-1:0] coord_from16(input logic [15:0] v);
		logic [31:0] t;
		t = {{16{v[15]}}, v};
		return t[COORD_BITS-1:0];
	endfunction

	// low 16 bits of a coordinate, zero-filled when the coordinate is narrower
	function automatic logic [15:0] coord_to16(input logic [COORD_BITS-1:0] v);
		logic [31:0] t;
		t = 32'(v);
		return t[15:0];
	endfunction

endpackage

>>> rtl/glyph_cell_rasterizer.sv
// glyph cell rasterizer top level: config registers, front end, queue, cell generator
// depends on gcr_pkg, gcr_front, gcr_queue, gcr_back and the assertion macro header
//
// usage
//   text bytes come in on the s_ group, one byte per beat; tuser set means the
//   cursor goes back to the origin before this byte
//   each byte other than newline gives 64 cell beats on the m_ group in row-major
//   order, leftmost cell first; tlast marks the 64th cell of a character
//   a newline moves the cursor to the next text line and gives no beats
//   registers are written through cfg_wr_en / cfg_index / cfg_data while idle
// timing
//   a taken byte is written into the queue, the walker loads it from there and the
//   cell register then takes its first cell; one cell per cycle after that while
//   m_tready is high, and characters follow each other with no gap when the next
//   one is already queued; the two-entry queue lets the front take bytes
//   while the back end is still drawing
// stall and reset
//   when m_tready is low with a beat pending, the cell register holds and the walker
//   waits; once the queue fills, s_tready drops
//   reset clears the cursor, the queue and the walker and loads register defaults:
//   origin 0,0, white foreground, black background, scale 1, tall mode off
`include "glyph_cell_rasterizer_macros.svh"

module glyph_cell_rasterizer
	import gcr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// config write port
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// text input
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [7:0] char_code
	input  logic                  s_tuser,   // [0] new_string
	// cell output
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [47:0]           m_tdata,   // [15:0] cell_x, [31:16] cell_y, [47:32] cell_color
	output logic                  m_tlast    // last_cell
);

	cfg_t     cfg_q;
	logic     push_valid;
	logic     push_ready;
	job_t     push_job;
	logic     pop_valid;
	logic     pop;
	job_t     pop_job;
	q_stat_t  q_stat;
	bk_stat_t bk_stat;
	logic [15:0] cell_x;
	logic [15:0] cell_y;
	logic [15:0] cell_color;
	logic     job_waiting;
	logic     last_beat;
	logic     nl_into_idle;

	// register file, writes take effect at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x     <= 16'h0000;
			cfg_q.origin_y     <= 16'h0000;
			cfg_q.fore_color   <= 16'hFFFF;
			cfg_q.back_color   <= 16'h0000;
			cfg_q.scale_factor <= 4'd1;
			cfg_q.tall_mode    <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_ORIGIN_X: cfg_q.origin_x     <= cfg_data;
				REG_ORIGIN_Y: cfg_q.origin_y     <= cfg_data;
				REG_FORE:     cfg_q.fore_color   <= cfg_data;
				REG_BACK:     cfg_q.back_color   <= cfg_data;
				REG_SCALE:    cfg_q.scale_factor <= cfg_data[3:0];
				REG_TALL:     cfg_q.tall_mode    <= cfg_data[0];
				default:      cfg_q              <= cfg_q;
			endcase
		end
	end

	// cursor tracking and glyph lookup
	gcr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.char_code  (s_tdata),
		.new_string (s_tuser),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	// decouples byte intake from cell drawing
	gcr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_job    (pop_job),
		.stat       (q_stat)
	);

	// walks 64 cells per character into the output register
	gcr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.job_valid  (pop_valid),
		.job_pop    (pop),
		.job        (pop_job),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.cell_x     (cell_x),
		.cell_y     (cell_y),
		.cell_color (cell_color),
		.last_cell  (m_tlast),
		.stat       (bk_stat)
	);

	assign m_tdata = {cell_color, cell_y, cell_x};

	// terms for the checks below
	assign job_waiting  = (q_stat.count != '0) && !bk_stat.busy;
	assign last_beat    = m_tvalid && m_tlast;
	assign nl_into_idle = s_tvalid && s_tready && (s_tdata == CHAR_NEWLINE)
		&& (q_stat.count == '0) && !bk_stat.busy && !m_tvalid;

	// a waiting job is picked up by an idle walker
	`GCR_ASSERT_NXT(a_job_pickup, job_waiting, bk_stat.busy, "queued job not picked up")
	// while the closing cell waits, the walker has wrapped its count
	`GCR_ASSERT_IMP(a_last_wrap, last_beat, bk_stat.cnt == '0, "cell count out of step")
	// a newline into an empty block produces no beat
	`GCR_ASSERT_NXT(a_newline_quiet, nl_into_idle, !m_tvalid, "newline produced a cell beat")

endmodule

>>> rtl/gcr_front.sv
// front end: takes text bytes, keeps the cursor and looks up glyphs
// depends on gcr_pkg
module gcr_front
	import gcr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_code,
	input  logic        new_string,
	output logic        push_valid,
	input  logic        push_ready,
	output job_t        push_job
);

	logic [COORD_BITS-1:0] cursor_x_q;
	logic [COORD_BITS-1:0] cursor_y_q;
	logic [COORD_BITS-1:0] base_x;
	logic [COORD_BITS-1:0] base_y;
	logic [4:0]            row_step;
	logic                  is_newline;
	logic                  accept;

	assign in_ready   = push_ready;
	assign accept     = in_valid && push_ready;
	assign is_newline = (char_code == CHAR_NEWLINE);
	assign push_valid = accept && !is_newline;

	always_comb begin
		base_x   = new_string ? coord_from16(cfg.origin_x) : cursor_x_q;
		base_y   = new_string ? coord_from16(cfg.origin_y) : cursor_y_q;
		row_step = cfg.tall_mode ? {cfg.scale_factor, 1'b0} : {1'b0, cfg.scale_factor};
		push_job.glyph = glyph_bits(char_code);
		push_job.cx    = base_x;
		push_job.cy    = base_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q <= '0;
			cursor_y_q <= '0;
		end else if (accept) begin
			if (is_newline) begin
				cursor_x_q <= coord_from16(cfg.origin_x);
				cursor_y_q <= base_y + COORD_BITS'({row_step, 3'b000});
			end else begin
				cursor_x_q <= base_x + COORD_BITS'({cfg.scale_factor, 3'b000});
				cursor_y_q <= base_y;
			end
		end
	end

endmodule

>>> rtl/gcr_queue.sv
// short job queue between the front end and the cell generator
// depends on gcr_pkg
module gcr_queue
	import gcr_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push_valid,
	output logic    push_ready,
	input  job_t    push_job,
	output logic    pop_valid,
	input  logic    pop,
	output job_t    pop_job,
	output q_stat_t stat
);

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != QCNT_W'(QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;
	assign pop_job    = mem_q[rd_ptr_q];
	assign stat.count = count_q;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/gcr_back.sv
// cell generator: walks the 64 cells of a glyph into an output register
// depends on gcr_pkg
module gcr_back
	import gcr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        job_valid,
	output logic        job_pop,
	input  job_t        job,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] cell_x,
	output logic [15:0] cell_y,
	output logic [15:0] cell_color,
	output logic        last_cell,
	output bk_stat_t    stat
);

	logic                  busy_q;
	logic [CELL_CNT_W-1:0] cnt_q;
	logic [GLYPH_BITS-1:0] glyph_q;
	logic [COORD_BITS-1:0] x_q;
	logic [COORD_BITS-1:0] y_q;
	logic [COORD_BITS-1:0] row_x_q;
	logic                  out_valid_q;
	logic [15:0]           cell_x_q;
	logic [15:0]           cell_y_q;
	logic [15:0]           cell_color_q;
	logic                  last_cell_q;
	logic                  adv;
	logic                  at_last;
	logic [4:0]            row_step;

	assign row_step = cfg.tall_mode ? {cfg.scale_factor, 1'b0} : {1'b0, cfg.scale_factor};
	assign at_last  = (cnt_q == CELL_LAST);
	assign adv      = busy_q && (!out_valid_q || out_ready);
	// next job loads while the last cell of the current one goes out
	assign job_pop  = job_valid && (!busy_q || (adv && at_last));

	assign out_valid  = out_valid_q;
	assign cell_x     = cell_x_q;
	assign cell_y     = cell_y_q;
	assign cell_color = cell_color_q;
	assign last_cell  = last_cell_q;
	assign stat.busy  = busy_q;
	assign stat.cnt   = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (job_pop) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (adv) begin
				cnt_q <= cnt_q + 1'b1;
				if (at_last) begin
					busy_q <= 1'b0;
				end
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			glyph_q <= job.glyph;
			x_q     <= job.cx;
			row_x_q <= job.cx;
			y_q     <= job.cy;
		end else if (adv) begin
			glyph_q <= glyph_q >> 1;
			if (cnt_q[2:0] == 3'b111) begin
				x_q <= row_x_q;
				y_q <= y_q + COORD_BITS'(row_step);
			end else begin
				x_q <= x_q + COORD_BITS'(cfg.scale_factor);
			end
		end
		if (adv) begin
			cell_x_q     <= coord_to16(x_q);
			cell_y_q     <= coord_to16(y_q);
			cell_color_q <= glyph_q[0] ? cfg.fore_color : cfg.back_color;
			last_cell_q  <= at_last;
		end
	end

endmodule
